### rtl/mprc_pkg.sv
// Shared types, constants and the button remap function of the mouse packet ring converter.
package mprc_pkg;

  // Item operation codes carried in the opcode field.
  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Field widths that the item format fixes.
  localparam int BYTE_W   = 8;
  localparam int BTN_W    = 3;
  localparam int SHIFT_W  = 2;
  localparam int POS_W    = 16;
  localparam int WAIT_W   = 9;
  localparam int REC_W    = 3 * BYTE_W;
  localparam int OFF_W    = 2;

  // Bytes in one stored record and the byte offset of its last byte.
  localparam int REC_BYTES = 3;
  localparam logic [OFF_W-1:0] LAST_OFF = 2'd2;

  // Cursor counters restart here.
  localparam logic [POS_W-1:0] POS_RESET = 16'd32;

  // Button codes as sent to the host; bit 7 is always set.
  localparam logic [BYTE_W-1:0] CODE_TABLE [8] = '{
    8'h87, 8'h86, 8'h83, 8'h82, 8'h85, 8'h84, 8'h81, 8'h80
  };

  // Remapped button codes with a shift key held.
  localparam logic [BTN_W-1:0] BTN_SINGLE_L = 3'h1;
  localparam logic [BTN_W-1:0] BTN_SINGLE_R = 3'h2;
  localparam logic [BTN_W-1:0] BTN_BOTH     = 3'h3;
  localparam logic [BTN_W-1:0] BTN_MIDDLE   = 3'h4;
  localparam logic [BTN_W-1:0] BTN_ALL      = 3'h7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the accepted input beat
    logic do_pkt;    // store a packet record and load the result
    logic rd_issue;  // read the record at the head
    logic do_rd;     // pop one byte and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;   // captured item is a read
    logic out_free;  // result register can take a new result this cycle
  } status_t;

  // With a shift key held, one button becomes middle and both become all three.
  function automatic logic [BYTE_W-1:0] convert_buttons(
    input logic [BTN_W-1:0]   buttons,
    input logic [SHIFT_W-1:0] shift
  );
    logic [BTN_W-1:0] b;
    b = buttons;
    if (shift != '0) begin
      if (buttons == BTN_SINGLE_L || buttons == BTN_SINGLE_R) begin
        b = BTN_MIDDLE;
      end else if (buttons == BTN_BOTH) begin
        b = BTN_ALL;
      end
    end
    return CODE_TABLE[b];
  endfunction

endpackage

### rtl/mprc_if.sv
// Valid/ready channel interfaces for the input and result beats.

// Input channel: one packet or read request per beat.
interface mprc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] status_byte;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic [1:0] shift_keys;

  modport source (output valid, opcode, status_byte, delta_x, delta_y, shift_keys,
                  input ready);
  modport sink   (input valid, opcode, status_byte, delta_x, delta_y, shift_keys,
                  output ready);
endinterface

// Result channel: one result per input beat.
interface mprc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        read_valid;
  logic [7:0]  read_byte;
  logic [8:0]  bytes_waiting;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;

  modport source (output valid, accepted, read_valid, read_byte, bytes_waiting,
                  cursor_x, cursor_y, input ready);
  modport sink   (input valid, accepted, read_valid, read_byte, bytes_waiting,
                  cursor_x, cursor_y, output ready);
endinterface

### rtl/mprc_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module mprc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mprc_pkg::status_t stat,
  output mprc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_MEMRD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_MEMRD;
        end else if (stat.out_free) begin
          cmd.do_pkt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MEMRD: begin
        if (stat.out_free) begin
          cmd.do_rd = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/mprc_dp.sv
// Datapath: input capture, record ring memory, pointers, cursor counters and result register.
module mprc_dp #(
  parameter int RING_RECORDS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mprc_pkg::cmd_t    cmd,
  output mprc_pkg::status_t stat,
  mprc_in_if.sink           in_bus,
  mprc_out_if.source        out_bus
);

  localparam int IDX_W  = (RING_RECORDS > 1) ? $clog2(RING_RECORDS) : 1;
  localparam int CNT_RAW = $clog2(3 * RING_RECORDS);
  localparam int CNT_W  = (CNT_RAW > mprc_pkg::WAIT_W) ? CNT_RAW : mprc_pkg::WAIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_RECORDS - 1);

  // Captured input beat.
  logic                            op_r;
  logic [mprc_pkg::BTN_W-1:0]      btn_r;
  logic [mprc_pkg::BYTE_W-1:0]     dx_r;
  logic [mprc_pkg::BYTE_W-1:0]     dy_r;
  logic [mprc_pkg::SHIFT_W-1:0]    sh_r;

  // Ring state and cursor counters.
  logic [IDX_W-1:0]                head_r, head_nxt;
  logic [IDX_W-1:0]                tail_r, tail_nxt;
  logic [mprc_pkg::OFF_W-1:0]      off_r, off_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [mprc_pkg::POS_W-1:0]      pos_x_r, pos_x_nxt;
  logic [mprc_pkg::POS_W-1:0]      pos_y_r, pos_y_nxt;

  // Record memory and its registered read data.
  logic [mprc_pkg::REC_W-1:0]      mem [RING_RECORDS];
  logic [mprc_pkg::REC_W-1:0]      rd_data_r;

  // Result register.
  logic                            out_valid_r;
  logic                            acc_r, acc_nxt;
  logic                            rvalid_r, rvalid_nxt;
  logic [mprc_pkg::BYTE_W-1:0]     rbyte_r, rbyte_nxt;

  // Helper signals.
  logic [IDX_W-1:0]                tail_inc;
  logic [IDX_W-1:0]                head_inc;
  logic                            full;
  logic                            empty;
  logic                            wr_en;
  logic [mprc_pkg::REC_W-1:0]      wr_rec;

  assign stat.is_read  = (op_r == mprc_pkg::OP_READ);
  assign stat.out_free = !out_valid_r || out_bus.ready;

  // Ring pointer arithmetic.
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign full     = (tail_inc == head_r);
  assign empty    = (head_r == tail_r);
  assign wr_en    = cmd.do_pkt && !full;
  assign wr_rec   = {8'(8'd0 - dy_r), dx_r,
                     mprc_pkg::convert_buttons(btn_r, sh_r)};

  // Next values of the ring, counters and result fields.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    off_nxt    = off_r;
    cnt_nxt    = cnt_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    acc_nxt    = 1'b0;
    rvalid_nxt = 1'b0;
    rbyte_nxt  = '0;
    if (wr_en) begin
      tail_nxt  = tail_inc;
      cnt_nxt   = cnt_r + CNT_W'(mprc_pkg::REC_BYTES);
      pos_x_nxt = pos_x_r + {{8{dx_r[7]}}, dx_r};
      pos_y_nxt = pos_y_r + {{8{dy_r[7]}}, dy_r};
      acc_nxt   = 1'b1;
    end
    if (cmd.do_rd && !empty) begin
      rvalid_nxt = 1'b1;
      case (off_r)
        2'd0:    rbyte_nxt = rd_data_r[7:0];
        2'd1:    rbyte_nxt = rd_data_r[15:8];
        default: rbyte_nxt = rd_data_r[23:16];
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (off_r == mprc_pkg::LAST_OFF) begin
        off_nxt  = '0;
        head_nxt = head_inc;
      end else begin
        off_nxt = off_r + 1'b1;
      end
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_bus.opcode;
      btn_r <= in_bus.status_byte[mprc_pkg::BTN_W-1:0];
      dx_r  <= in_bus.delta_x;
      dy_r  <= in_bus.delta_y;
      sh_r  <= in_bus.shift_keys;
    end
  end

  // Record memory: one write port, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_rec;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[head_r];
    end
  end

  // Ring pointers, byte count and cursor counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      off_r   <= '0;
      cnt_r   <= '0;
      pos_x_r <= mprc_pkg::POS_RESET;
      pos_y_r <= mprc_pkg::POS_RESET;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      off_r   <= off_nxt;
      cnt_r   <= cnt_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_pkt || cmd.do_rd) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with the state after the item.
  always_ff @(posedge clk) begin
    if (cmd.do_pkt || cmd.do_rd) begin
      acc_r    <= acc_nxt;
      rvalid_r <= rvalid_nxt;
      rbyte_r  <= rbyte_nxt;
    end
  end

  logic [mprc_pkg::WAIT_W-1:0] wait_r;
  logic [mprc_pkg::POS_W-1:0]  cx_r;
  logic [mprc_pkg::POS_W-1:0]  cy_r;

  always_ff @(posedge clk) begin
    if (cmd.do_pkt || cmd.do_rd) begin
      wait_r <= cnt_nxt[mprc_pkg::WAIT_W-1:0];
      cx_r   <= pos_x_nxt;
      cy_r   <= pos_y_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.accepted      = acc_r;
  assign out_bus.read_valid    = rvalid_r;
  assign out_bus.read_byte     = rbyte_r;
  assign out_bus.bytes_waiting = wait_r;
  assign out_bus.cursor_x      = cx_r;
  assign out_bus.cursor_y      = cy_r;

endmodule

### rtl/mouse_packet_ring_converter_core.sv
// Top level of the mouse packet ring converter: controller plus datapath.
//
//   channel   | dir | handshake     | payload
//   in_bus    | in  | valid / ready | opcode, status_byte, delta_x, delta_y, shift_keys
//   out_bus   | out | valid / ready | accepted, read_valid, read_byte, bytes_waiting,
//             |     |               | cursor_x, cursor_y
//
// A packet beat passes from the input capture register to the result register; a read beat
// also passes through the registered read port of the single record memory in between.
// One beat is in work at a time; a new input beat is taken while the last result
// still waits, and work stalls before loading the result register until it frees.
// Reset (rst_n low, synchronous) empties the ring and sets both cursors to 32.
module mouse_packet_ring_converter_core #(
  parameter int RING_RECORDS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  mprc_in_if.sink    in_bus,
  mprc_out_if.source out_bus
);

  mprc_pkg::cmd_t    cmd;
  mprc_pkg::status_t stat;
  logic              ctrl_ready;

  // Sequencer.
  mprc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The sequencer decides when an input beat is taken.
  assign in_bus.ready = ctrl_ready;

  // Ring, counters and result register.
  mprc_dp #(
    .RING_RECORDS (RING_RECORDS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

### rtl/mprc_checker.sv
// Port-level assertions for the mouse packet ring converter, bound to the top level.
module mprc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic        read_valid,
  input logic [7:0]  read_byte,
  input logic [8:0]  bytes_waiting
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its read byte and byte count.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(read_byte) && $stable(bytes_waiting))
    else $error("result payload changed while stalled");

  // A result never both stores a packet and pops a byte.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(accepted && read_valid))
    else $error("result flags both a stored packet and a popped byte");

  // Without a popped byte the byte field reads zero.
  a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_valid |-> read_byte == 8'd0)
    else $error("read byte nonzero without a popped byte");

endmodule

bind mouse_packet_ring_converter_core mprc_checker u_mprc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .accepted      (out_bus.accepted),
  .read_valid    (out_bus.read_valid),
  .read_byte     (out_bus.read_byte),
  .bytes_waiting (out_bus.bytes_waiting)
);

### verif/tb_top.sv
// Testbench for the mouse packet ring converter: directed and random beats checked by a predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  localparam int RING_DEPTH   = 128;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int WRAP_PACKETS = 160;
  localparam int RANDOM_BEATS = 80;
  localparam int STEADY_BEATS = 40;

  localparam logic [15:0] CURSOR_HOME = 16'd32;

  // Host code for each button state after the shift remap.
  localparam logic [7:0] HOST_CODE [8] = '{
    8'h87, 8'h86, 8'h83, 8'h82, 8'h85, 8'h84, 8'h81, 8'h80
  };

  // Delta values at and around the signed extremes.
  localparam logic [7:0] EDGE_DELTA [4] = '{8'h80, 8'h7f, 8'h00, 8'hff};

  typedef struct packed {
    mprc_pkg::op_t     opcode;
    logic [7:0]        status_byte;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [1:0]        shift_keys;
  } mouse_beat_t;

  typedef struct packed {
    logic               accepted;
    logic               read_valid;
    logic [7:0]         read_byte;
    logic [8:0]         bytes_waiting;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
  } mouse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mprc_in_if  in_ch ();
  mprc_out_if out_ch ();

  mouse_packet_ring_converter_core #(
    .RING_RECORDS(RING_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Predicted ring contents, pointers and cursor counters.
  logic [23:0]        ring_rec [RING_DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_tail = 0;
  int unsigned        ring_off  = 0;
  logic [15:0]        cur_x = CURSOR_HOME;
  logic [15:0]        cur_y = CURSOR_HOME;
  mouse_result_t      pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_left     = 0;
  bit          in_idle_en     = 1'b1;
  bit          out_idle_en    = 1'b1;
  bit          hold_req       = 1'b0;

  // Bytes still queued in the predicted ring.
  function automatic int unsigned ring_bytes();
    int unsigned recs;
    recs = (ring_tail + RING_DEPTH - ring_head) % RING_DEPTH;
    return recs * 3 - ring_off;
  endfunction

  // Applies one accepted beat to the predicted state and returns its result.
  function automatic mouse_result_t predict_beat(mouse_beat_t b);
    mouse_result_t r;
    logic [2:0]    btn;
    logic [7:0]    neg_dy;
    int unsigned   next_tail;
    r = '0;
    if (b.opcode == mprc_pkg::OP_PACKET) begin
      next_tail = (ring_tail + 1) % RING_DEPTH;
      // A full ring drops the packet and leaves the cursors alone.
      if (next_tail != ring_head) begin
        btn = b.status_byte[2:0];
        if (b.shift_keys != 2'b00) begin
          if (btn == mprc_pkg::BTN_SINGLE_L || btn == mprc_pkg::BTN_SINGLE_R) begin
            btn = mprc_pkg::BTN_MIDDLE;
          end else if (btn == mprc_pkg::BTN_BOTH) begin
            btn = mprc_pkg::BTN_ALL;
          end
        end
        neg_dy = 8'd0 - b.delta_y;
        ring_rec[ring_tail] = {neg_dy, b.delta_x, HOST_CODE[btn]};
        ring_tail = next_tail;
        cur_x = cur_x + {{8{b.delta_x[7]}}, b.delta_x};
        cur_y = cur_y + {{8{b.delta_y[7]}}, b.delta_y};
        r.accepted = 1'b1;
      end
    end else begin
      // Pop one byte of the head record; an empty ring returns nothing.
      if (ring_head != ring_tail) begin
        r.read_valid = 1'b1;
        r.read_byte  = ring_rec[ring_head][ring_off*8 +: 8];
        ring_off++;
        if (ring_off == 3) begin
          ring_off  = 0;
          ring_head = (ring_head + 1) % RING_DEPTH;
        end
      end
    end
    r.bytes_waiting = 9'(ring_bytes());
    r.cursor_x      = cur_x;
    r.cursor_y      = cur_y;
    return r;
  endfunction

  function automatic mouse_beat_t rand_packet();
    mouse_beat_t b;
    b.opcode      = mprc_pkg::OP_PACKET;
    b.status_byte = 8'($urandom);
    b.delta_x     = 8'($urandom);
    b.delta_y     = 8'($urandom);
    b.shift_keys  = 2'($urandom);
    return b;
  endfunction

  // Read beats carry random content in the fields they do not use.
  function automatic mouse_beat_t rand_read();
    mouse_beat_t b;
    b        = rand_packet();
    b.opcode = mprc_pkg::OP_READ;
    return b;
  endfunction

  task automatic note_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  // Offers one beat, starting and ending at a falling edge, with an optional gap first.
  task automatic send_beat(input mouse_beat_t b);
    int unsigned gap;
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode      = b.opcode;
    in_ch.status_byte = b.status_byte;
    in_ch.delta_x     = b.delta_x;
    in_ch.delta_y     = b.delta_y;
    in_ch.shift_keys  = b.shift_keys;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Result side: checks every accepted result, then predicts every accepted input beat.
  always @(posedge clk) begin : result_check
    mouse_result_t seen;
    mouse_result_t want;
    mouse_beat_t   beat;
    if (rst_n) begin
      quiet_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles       = 0;
        seen.accepted      = out_ch.accepted;
        seen.read_valid    = out_ch.read_valid;
        seen.read_byte     = out_ch.read_byte;
        seen.bytes_waiting = out_ch.bytes_waiting;
        seen.cursor_x      = out_ch.cursor_x;
        seen.cursor_y      = out_ch.cursor_y;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result beat with none expected", $time);
          end
        end else begin
          want = pending_results.pop_front();
          note_field("accepted", want.accepted, seen.accepted);
          note_field("read_valid", want.read_valid, seen.read_valid);
          note_field("read_byte", want.read_byte, seen.read_byte);
          note_field("bytes_waiting", want.bytes_waiting, seen.bytes_waiting);
          note_field("cursor_x", want.cursor_x, seen.cursor_x);
          note_field("cursor_y", want.cursor_y, seen.cursor_y);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles     = 0;
        beat.opcode      = mprc_pkg::op_t'(in_ch.opcode);
        beat.status_byte = in_ch.status_byte;
        beat.delta_x     = in_ch.delta_x;
        beat.delta_y     = in_ch.delta_y;
        beat.shift_keys  = in_ch.shift_keys;
        pending_results.push_back(predict_beat(beat));
      end
      // Watchdog on cycles where neither channel moves a beat.
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver pacing: short random stalls, plus one long hold when requested.
  always @(negedge clk) begin : result_pacing
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      stall_left   = HOLD_CYCLES - 1;
      out_ch.ready = 1'b0;
    end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(0, 9);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Empty-ring read, every button state with and without shift, delta extremes.
  task automatic test_directed();
    mouse_beat_t b;
    int unsigned n;
    send_beat(rand_read());
    for (n = 0; n < 16; n++) begin
      b             = rand_packet();
      b.status_byte = (n < 8) ? {5'h00, 3'(n)} : {5'h1f, 3'(n)};
      b.shift_keys  = (n < 8) ? 2'b00 : 2'(1 + n % 3);
      b.delta_x     = EDGE_DELTA[n % 4];
      b.delta_y     = EDGE_DELTA[n / 4];
      send_beat(b);
    end
    repeat (6) send_beat(rand_read());
  endtask

  // Overfills the ring so packets drop, then drains it and reads it empty.
  task automatic test_ring_full();
    mouse_beat_t b;
    int unsigned n_reads;
    repeat (RING_DEPTH + 2) begin
      b         = rand_packet();
      b.delta_x = 8'h7f;
      b.delta_y = 8'h80;
      send_beat(b);
    end
    n_reads = ring_bytes() + 2;
    repeat (n_reads) send_beat(rand_read());
  endtask

  // Maximal deltas carry both cursors past the 16-bit signed range.
  task automatic test_cursor_wrap();
    mouse_beat_t b;
    repeat (WRAP_PACKETS) begin
      b         = rand_packet();
      b.delta_x = 8'h7f;
      b.delta_y = 8'h80;
      send_beat(b);
      repeat (3) send_beat(rand_read());
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    in_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (30) send_beat(($urandom_range(0, 1) == 0) ? rand_packet() : rand_read());
    in_idle_en = 1'b1;
  endtask

  // Mostly packet bursts read back in full, with partial reads, read runs and noise.
  task automatic test_random_traffic(input int unsigned beats);
    mouse_beat_t b;
    int unsigned sent;
    int unsigned kind;
    int unsigned burst;
    int unsigned reads;
    sent = 0;
    while (sent < beats) begin
      kind  = $urandom_range(0, 9);
      burst = (kind == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if (kind <= 7) begin
        repeat (burst) send_beat(rand_packet());
        reads = 3 * burst;
        if (kind == 7) begin
          reads = $urandom_range(0, reads + 4);
        end
        repeat (reads) send_beat(rand_read());
        sent += burst + reads;
      end else if (kind == 8) begin
        repeat (burst) send_beat(rand_read());
        sent += burst;
      end else begin
        b        = rand_packet();
        b.opcode = mprc_pkg::op_t'($urandom_range(0, 1));
        send_beat(b);
        sent++;
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_traffic(STEADY_BEATS);
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = mprc_pkg::OP_PACKET;
    in_ch.status_byte = '0;
    in_ch.delta_x     = '0;
    in_ch.delta_y     = '0;
    in_ch.shift_keys  = '0;
    out_ch.ready      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_ring_full();
    test_cursor_wrap();
    test_backpressure();
    test_random_traffic(RANDOM_BEATS);
    test_steady_stream();

    // Let every outstanding result arrive, then watch for strays.
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
